/* rtl/core/ami_pkg.sv */
// shared types, constants and helper functions of the affine matrix inverse core
`default_nettype none

package ami_pkg;

    localparam int unsigned ELEM_W  = 32;
    localparam int unsigned N_LIN   = 9;
    localparam int unsigned PROD_W  = 64;
    localparam int unsigned ADJ_W   = 65;
    localparam int unsigned MAG_W   = 64;
    localparam int unsigned DETS_W  = 98;
    localparam int unsigned DMAG_W  = 96;
    localparam int unsigned QUOT_W  = 33;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned SEL_W   = 2;
    localparam int unsigned ADDR_W  = 3;

    // register index, taken from paddr[2]
    localparam logic REG_MIN_DET = 1'b0;
    localparam logic [ELEM_W-1:0] MIN_DET_RESET = 32'd1;

    localparam logic [IDX_W-1:0] LAST_LIN     = 4'd8;
    localparam logic [SEL_W-1:0] LAST_TRANS   = 2'd2;
    localparam logic [POS_W-1:0] POS_SINGULAR = 4'd0;
    localparam logic [POS_W-1:0] POS_TRANS    = 4'd12;

    // operand indexes of each cofactor x*y - z*w, elements a..i in row-major order
    localparam logic [IDX_W-1:0] COF_IDX [N_LIN][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic [N_LIN-1:0][ELEM_W-1:0] lin;
        logic [2:0][ELEM_W-1:0]       trans;
    } mat_t;

    typedef struct packed {
        logic                         sing;
        logic                         det_neg;
        logic [DMAG_W-1:0]            det_mag;
        logic [N_LIN-1:0]             adj_neg;
        logic [N_LIN-1:0][MAG_W-1:0]  adj_mag;
        logic [2:0][ELEM_W-1:0]       trans;
    } front_out_t;

    typedef struct packed {
        logic                   sing;
        logic [IDX_W-1:0]       idx;
        logic                   neg;
        logic [MAG_W-1:0]       adj_mag;
        logic [DMAG_W-1:0]      det_mag;
        logic [2:0][ELEM_W-1:0] trans;
    } div_req_t;

    typedef struct packed {
        logic                   sing;
        logic [IDX_W-1:0]       idx;
        logic                   neg;
        logic [QUOT_W-1:0]      quot;
        logic [2:0][ELEM_W-1:0] trans;
    } div_rsp_t;

    function automatic logic [POS_W-1:0] lin_pos(input logic [IDX_W-1:0] idx);
        logic [POS_W-1:0] p;
        case (idx)
            4'd0:    p = 4'd0;
            4'd1:    p = 4'd1;
            4'd2:    p = 4'd2;
            4'd3:    p = 4'd4;
            4'd4:    p = 4'd5;
            4'd5:    p = 4'd6;
            4'd6:    p = 4'd8;
            4'd7:    p = 4'd9;
            4'd8:    p = 4'd10;
            default: p = 4'd0;
        endcase
        return p;
    endfunction

    // sign-magnitude to saturated two's complement
    function automatic logic [ELEM_W-1:0] sat_quot(input logic neg, input logic [QUOT_W-1:0] q);
        logic [ELEM_W-1:0] r;
        if (neg)
        begin
            r = (q >= 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - q[ELEM_W-1:0]);
        end
        else
        begin
            r = (q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[ELEM_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ami_in_if.sv */
// input channel: one affine transform per transfer
`default_nettype none

interface ami_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] lin_00;
    logic signed [31:0] lin_01;
    logic signed [31:0] lin_02;
    logic signed [31:0] lin_10;
    logic signed [31:0] lin_11;
    logic signed [31:0] lin_12;
    logic signed [31:0] lin_20;
    logic signed [31:0] lin_21;
    logic signed [31:0] lin_22;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;

    modport source (
        output valid, lin_00, lin_01, lin_02, lin_10, lin_11, lin_12,
               lin_20, lin_21, lin_22, trans_x, trans_y, trans_z,
        input  ready
    );
    modport sink (
        input  valid, lin_00, lin_01, lin_02, lin_10, lin_11, lin_12,
               lin_20, lin_21, lin_22, trans_x, trans_y, trans_z,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/ami_out_if.sv */
// result channel: one inverse element per transfer
`default_nettype none

interface ami_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         position;
    logic signed [31:0] value;
    logic               singular;
    logic               last;

    modport source (output valid, position, value, singular, last, input ready);
    modport sink (input valid, position, value, singular, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/ami_front.sv */
// cofactor and determinant pipeline with singular test
`default_nettype none

module ami_front #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ami_pkg::mat_t        in_data,
    input  logic [31:0]          min_det,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ami_pkg::front_out_t  out_data
);
    import ami_pkg::*;

    localparam int unsigned DEPTH = 5;

    logic [DEPTH-1:0] v_reg;
    logic             en;

    logic signed [PROD_W-1:0]   pp1_reg [N_LIN];
    logic signed [PROD_W-1:0]   pq1_reg [N_LIN];
    logic [2:0][ELEM_W-1:0]     lead1_reg;
    logic [2:0][ELEM_W-1:0]     t1_reg;

    logic signed [ADJ_W-1:0]    adj2_reg [N_LIN];
    logic [2:0][ELEM_W-1:0]     lead2_reg;
    logic [2:0][ELEM_W-1:0]     t2_reg;

    logic signed [ADJ_W-1:0]    plo3_reg [3];
    logic signed [ADJ_W-1:0]    phi3_reg [3];
    logic [N_LIN-1:0]           neg3_reg;
    logic [N_LIN-1:0][MAG_W-1:0] mag3_reg;
    logic [2:0][ELEM_W-1:0]     t3_reg;

    logic signed [DETS_W-1:0]   det4_reg;
    logic [N_LIN-1:0]           neg4_reg;
    logic [N_LIN-1:0][MAG_W-1:0] mag4_reg;
    logic [2:0][ELEM_W-1:0]     t4_reg;

    front_out_t                 out_reg;

    logic signed [ADJ_W-1:0]    adj_abs [N_LIN];
    logic signed [DETS_W-1:0]   det_sum;
    logic signed [DETS_W-1:0]   det_abs;
    logic [DMAG_W-1:0]          det_mag;
    logic [DMAG_W-1:0]          thresh;

    assign en        = !v_reg[DEPTH-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[DEPTH-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
        end
    end

    // stage 1: the eighteen cofactor products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_LIN; k++)
            begin
                pp1_reg[k] <= $signed(in_data.lin[COF_IDX[k][0]])
                            * $signed(in_data.lin[COF_IDX[k][1]]);
                pq1_reg[k] <= $signed(in_data.lin[COF_IDX[k][2]])
                            * $signed(in_data.lin[COF_IDX[k][3]]);
            end
            for (int m = 0; m < 3; m++)
            begin
                lead1_reg[m] <= in_data.lin[m];
            end
            t1_reg <= in_data.trans;
        end
    end

    // stage 2: adjugate elements
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_LIN; k++)
            begin
                adj2_reg[k] <= ADJ_W'(pp1_reg[k]) - ADJ_W'(pq1_reg[k]);
            end
            lead2_reg <= lead1_reg;
            t2_reg    <= t1_reg;
        end
    end

    // stage 3: determinant partial products, adjugate in sign-magnitude
    always_comb
    begin
        for (int k = 0; k < N_LIN; k++)
        begin
            adj_abs[k] = adj2_reg[k][ADJ_W-1] ? -adj2_reg[k] : adj2_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int m = 0; m < 3; m++)
            begin
                plo3_reg[m] <= $signed({1'b0, adj2_reg[3*m][31:0]}) * $signed(lead2_reg[m]);
                phi3_reg[m] <= $signed(adj2_reg[3*m][ADJ_W-1:32]) * $signed(lead2_reg[m]);
            end
            for (int k = 0; k < N_LIN; k++)
            begin
                neg3_reg[k] <= adj2_reg[k][ADJ_W-1];
                mag3_reg[k] <= adj_abs[k][MAG_W-1:0];
            end
            t3_reg <= t2_reg;
        end
    end

    // stage 4: determinant sum
    always_comb
    begin
        det_sum = '0;
        for (int m = 0; m < 3; m++)
        begin
            det_sum = det_sum + (DETS_W'(phi3_reg[m]) <<< 32) + DETS_W'(plo3_reg[m]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det4_reg <= det_sum;
            neg4_reg <= neg3_reg;
            mag4_reg <= mag3_reg;
            t4_reg   <= t3_reg;
        end
    end

    // stage 5: magnitude and threshold compare
    assign det_abs = det4_reg[DETS_W-1] ? -det4_reg : det4_reg;
    assign det_mag = det_abs[DMAG_W-1:0];
    assign thresh  = DMAG_W'(min_det) << (2 * FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.sing    <= (det_mag == '0) || (det_mag < thresh);
            out_reg.det_neg <= det4_reg[DETS_W-1];
            out_reg.det_mag <= det_mag;
            out_reg.adj_neg <= neg4_reg;
            out_reg.adj_mag <= mag4_reg;
            out_reg.trans   <= t4_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ami_div.sv */
// pipelined restoring divider, one quotient bit per stage, rounded to nearest
`default_nettype none

module ami_div #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ami_pkg::div_req_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ami_pkg::div_rsp_t  rsp
);
    import ami_pkg::*;

    localparam int unsigned STAGES = QUOT_W + 1;
    localparam int unsigned DEN_W  = DMAG_W + 1;
    localparam int unsigned REM_W  = 2 * FRAC_BITS + DMAG_W + QUOT_W + 2;

    logic [STAGES-1:0]       v_reg;
    logic                    en;
    logic                    sing_reg  [STAGES];
    logic [IDX_W-1:0]        idx_reg   [STAGES];
    logic                    neg_reg   [STAGES];
    logic [REM_W-1:0]        rem_reg   [STAGES];
    logic [DEN_W-1:0]        den_reg   [STAGES];
    logic [QUOT_W-1:0]       q_reg     [STAGES];
    logic [2:0][ELEM_W-1:0]  trans_reg [STAGES];

    assign en        = !v_reg[STAGES-1] || rsp_ready;
    assign req_ready = en;
    assign rsp_valid = v_reg[STAGES-1];

    assign rsp.sing  = sing_reg[STAGES-1];
    assign rsp.idx   = idx_reg[STAGES-1];
    assign rsp.neg   = neg_reg[STAGES-1];
    assign rsp.quot  = q_reg[STAGES-1];
    assign rsp.trans = trans_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[STAGES-2:0], req_valid};
        end
    end

    // numerator 2*adj*2^(2f) + det over divisor 2*det gives the rounded quotient
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg[0]  <= req.sing;
            idx_reg[0]   <= req.idx;
            neg_reg[0]   <= req.neg;
            rem_reg[0]   <= (REM_W'(req.adj_mag) << (2 * FRAC_BITS + 1)) + REM_W'(req.det_mag);
            den_reg[0]   <= {req.det_mag, 1'b0};
            q_reg[0]     <= '0;
            trans_reg[0] <= req.trans;
        end
    end

    // top quotient bit flags overflow, which later saturates
    for (genvar s = 1; s < STAGES; s++)
    begin : g_bit
        localparam int unsigned B = STAGES - 1 - s;
        logic [REM_W-1:0] shifted;
        logic             fits;

        assign shifted = REM_W'(den_reg[s-1]) << B;
        assign fits    = rem_reg[s-1] >= shifted;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sing_reg[s]  <= sing_reg[s-1];
                idx_reg[s]   <= idx_reg[s-1];
                neg_reg[s]   <= neg_reg[s-1];
                rem_reg[s]   <= fits ? (rem_reg[s-1] - shifted) : rem_reg[s-1];
                den_reg[s]   <= den_reg[s-1];
                q_reg[s]     <= q_reg[s-1] | (QUOT_W'(fits) << B);
                trans_reg[s] <= trans_reg[s-1];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ami_xlat.sv */
// inverse translation: products, sum, rounding and saturation
`default_nettype none

module ami_xlat #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [2:0][ami_pkg::ELEM_W-1:0]             trans,
    input  logic [ami_pkg::N_LIN-1:0][ami_pkg::ELEM_W-1:0] el,
    output logic                                        busy,
    output logic                                        res_valid,
    input  logic                                        res_ready,
    output logic [ami_pkg::ELEM_W-1:0]                  res_value,
    output logic [ami_pkg::SEL_W-1:0]                   res_sel
);
    import ami_pkg::*;

    localparam int unsigned SUM_W = PROD_W + 2;

    logic                     issuing_reg;
    logic [SEL_W-1:0]         j_reg;
    logic [2:0][ELEM_W-1:0]   t_reg;
    logic                     tp_valid_reg;
    logic [SEL_W-1:0]         tp_j_reg;
    logic signed [PROD_W-1:0] tp_reg [3];
    logic                     res_valid_reg;
    logic [SEL_W-1:0]         res_j_reg;
    logic [ELEM_W-1:0]        res_value_reg;

    logic                     res_en;
    logic                     tp_en;
    logic                     issue;
    logic [IDX_W-1:0]         col;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  mag;
    logic [SUM_W-1:0]         rnd;
    logic [QUOT_W-1:0]        rnd_sat;

    assign res_en    = !res_valid_reg || res_ready;
    assign tp_en     = !tp_valid_reg || res_en;
    assign issue     = issuing_reg && tp_en;
    assign col       = IDX_W'(j_reg);
    assign busy      = issuing_reg || tp_valid_reg || res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_value = res_value_reg;
    assign res_sel   = res_j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg   <= 1'b0;
            j_reg         <= '0;
            tp_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                issuing_reg <= 1'b1;
                j_reg       <= '0;
            end
            else if (issue)
            begin
                j_reg <= j_reg + 1'b1;
                if (j_reg == LAST_TRANS)
                begin
                    issuing_reg <= 1'b0;
                end
            end
            if (tp_en)
            begin
                tp_valid_reg <= issue;
            end
            if (res_en)
            begin
                res_valid_reg <= tp_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            t_reg <= trans;
        end
        if (issue)
        begin
            tp_reg[0] <= $signed(el[col])          * $signed(t_reg[0]);
            tp_reg[1] <= $signed(el[col + 4'd3])   * $signed(t_reg[1]);
            tp_reg[2] <= $signed(el[col + 4'd6])   * $signed(t_reg[2]);
            tp_j_reg  <= j_reg;
        end
    end

    // negate, round the magnitude half away from zero, saturate
    assign sum     = SUM_W'(tp_reg[0]) + SUM_W'(tp_reg[1]) + SUM_W'(tp_reg[2]);
    assign mag     = sum[SUM_W-1] ? -sum : sum;
    assign rnd     = (mag + (SUM_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign rnd_sat = (rnd >> QUOT_W) != '0 ? '1 : rnd[QUOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (res_en && tp_valid_reg)
        begin
            res_value_reg <= sat_quot(!sum[SUM_W-1], rnd_sat);
            res_j_reg     <= tp_j_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/affine_matrix_inverse_core.sv */
// top level of the affine 3x4 matrix inverse core
//
//  channel   | role   | handshake       | contents
//  ----------+--------+-----------------+---------------------------------------------
//  in_ch     | sink   | valid / ready   | lin_00..lin_22, trans_x..trans_z (Q16.16)
//  out_ch    | source | valid / ready   | position, value, singular, last
//  apb       | slave  | psel / penable  | min_det_magnitude at byte address 0
//
//  a regular matrix gives twelve result transfers, a singular one a single transfer
//  sustained rate: one singular matrix per cycle while out_ch is not stalled and no translation
//  is draining; a regular matrix is limited by the single result port (nine divider results, then
//  the three translation results, while the divider is held as the product and sum stages fill)
//  the first result reaches out_ch through five cofactor and determinant stages, the job
//  register, 34 divider stages and the output register
//  rst_n clears all valid bits and loads min_det_magnitude with 1, no clearing pass
//  a stall on out_ch holds the divider and front pipelines, which close up only empty stages; nothing is dropped
`default_nettype none

module affine_matrix_inverse_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ami_in_if.sink                      in_ch,
    ami_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ami_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ami_pkg::*;

    // configuration
    logic [ELEM_W-1:0] min_det_reg;
    logic              cfg_wr;

    // front pipeline
    mat_t        in_data;
    logic        front_valid;
    logic        front_ready;
    front_out_t  front_data;

    // sequencer: one matrix, issues one division per cycle while the divider accepts
    logic             job_valid_reg;
    front_out_t       job_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic             issue;
    logic             issue_last;
    div_req_t         req;
    logic             req_ready;

    // divider results
    div_rsp_t          rsp;
    logic              rsp_valid;
    logic              rsp_ready;
    logic [ELEM_W-1:0] lin_value;
    logic              div_take;

    // translation unit
    logic                         x_start;
    logic                         x_busy;
    logic                         x_valid;
    logic [ELEM_W-1:0]            x_value;
    logic [SEL_W-1:0]             x_sel;
    logic [N_LIN-1:0][ELEM_W-1:0] el_reg;

    // output register
    logic              out_valid_reg;
    logic [POS_W-1:0]  position_reg;
    logic [ELEM_W-1:0] value_reg;
    logic              singular_reg;
    logic              last_reg;
    logic              out_free;

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MIN_DET) ? min_det_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_det_reg <= MIN_DET_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_MIN_DET))
        begin
            min_det_reg <= pwdata;
        end
    end

    // ---------------------------------------------------------------- front
    assign in_data.lin[0]   = in_ch.lin_00;
    assign in_data.lin[1]   = in_ch.lin_01;
    assign in_data.lin[2]   = in_ch.lin_02;
    assign in_data.lin[3]   = in_ch.lin_10;
    assign in_data.lin[4]   = in_ch.lin_11;
    assign in_data.lin[5]   = in_ch.lin_12;
    assign in_data.lin[6]   = in_ch.lin_20;
    assign in_data.lin[7]   = in_ch.lin_21;
    assign in_data.lin[8]   = in_ch.lin_22;
    assign in_data.trans[0] = in_ch.trans_x;
    assign in_data.trans[1] = in_ch.trans_y;
    assign in_data.trans[2] = in_ch.trans_z;

    ami_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_data),
        .min_det   (min_det_reg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // ---------------------------------------------------------------- sequencer
    // a singular matrix issues a single token so that it keeps its place in order
    assign issue       = job_valid_reg && req_ready;
    assign issue_last  = issue && (job_reg.sing || (cnt_reg == LAST_LIN));
    assign front_ready = !job_valid_reg || issue_last;

    assign req.sing    = job_reg.sing;
    assign req.idx     = cnt_reg;
    assign req.neg     = job_reg.adj_neg[cnt_reg] ^ job_reg.det_neg;
    assign req.adj_mag = job_reg.adj_mag[cnt_reg];
    assign req.det_mag = job_reg.det_mag;
    assign req.trans   = job_reg.trans;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (front_ready)
        begin
            job_valid_reg <= front_valid;
            cnt_reg       <= '0;
        end
        else if (issue)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_ready && front_valid)
        begin
            job_reg <= front_data;
        end
    end

    ami_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (job_valid_reg),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // ---------------------------------------------------------------- output side
    // the divider waits while the translation of the previous matrix drains,
    // which also keeps el_reg stable for the translation unit
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign rsp_ready = out_free && !x_busy;
    assign div_take  = rsp_valid && rsp_ready;
    assign lin_value = sat_quot(rsp.neg, rsp.quot);
    assign x_start   = div_take && !rsp.sing && (rsp.idx == LAST_LIN);

    always_ff @(posedge clk)
    begin
        if (div_take && !rsp.sing)
        begin
            el_reg[rsp.idx] <= lin_value;
        end
    end

    ami_xlat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xlat (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (x_start),
        .trans     (rsp.trans),
        .el        (el_reg),
        .busy      (x_busy),
        .res_valid (x_valid),
        .res_ready (out_free),
        .res_value (x_value),
        .res_sel   (x_sel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= x_valid || div_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && x_valid)
        begin
            position_reg <= POS_TRANS + POS_W'(x_sel);
            value_reg    <= x_value;
            singular_reg <= 1'b0;
            last_reg     <= (x_sel == LAST_TRANS);
        end
        else if (div_take)
        begin
            if (rsp.sing)
            begin
                position_reg <= POS_SINGULAR;
                value_reg    <= '0;
                singular_reg <= 1'b1;
                last_reg     <= 1'b1;
            end
            else
            begin
                position_reg <= lin_pos(rsp.idx);
                value_reg    <= lin_value;
                singular_reg <= 1'b0;
                last_reg     <= 1'b0;
            end
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.position = position_reg;
    assign out_ch.value    = value_reg;
    assign out_ch.singular = singular_reg;
    assign out_ch.last     = last_reg;

    // ---------------------------------------------------------------- checks
    a_sing_result : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && singular_reg |-> last_reg && (position_reg == POS_SINGULAR))
        else $error("singular transfer not a lone last transfer at position 0");

    a_last_pos : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> singular_reg || (position_reg == (POS_TRANS + 4'd2)))
        else $error("last flag on a transfer other than the final translation");

    a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (cnt_reg <= LAST_LIN))
        else $error("sequencer count beyond the last linear element");

    a_xlat_hold : assert property (@(posedge clk) disable iff (!rst_n)
        x_start |=> x_busy && !rsp_ready)
        else $error("divider not held after the last linear element");

endmodule

`default_nettype wire
